/* hdl/rqs_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// rqs_pkg - request queue scheduler shared types
// Item structs, slot/candidate structs, cell command group and codes.
// ============================================================================
package rqs_pkg;

    localparam int CONN_W     = 16;
    localparam int SIZE_W     = 32;
    localparam int MTIME_W    = 32;
    localparam int OCC_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int POLICY_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // service policy codes (code three behaves as FIFO)
    localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;
    localparam logic [POLICY_W-1:0] POL_SFF  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_RFF  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // operation codes
    localparam logic FN_ENQ = 1'b0;
    localparam logic FN_DEQ = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS  = 2'd1;

    localparam logic [CFG_DATA_W-1:0] SLOTS_RESET = 5'd16;

    typedef struct packed {
        logic               func;
        logic [CONN_W-1:0]  conn_id;
        logic [SIZE_W-1:0]  file_size;
        logic [MTIME_W-1:0] mod_time;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CONN_W-1:0]   served_conn;
        logic [OCC_W-1:0]    occupancy;
    } t_out_item;

    typedef struct packed {
        logic [CONN_W-1:0]  conn_id;
        logic [SIZE_W-1:0]  file_size;
        logic [MTIME_W-1:0] mod_time;
    } t_slot;

    // best-so-far candidate rippling down the cell chain
    typedef struct packed {
        logic [SIZE_W-1:0] key;
        logic [CONN_W-1:0] conn_id;
        logic              found;
    } t_cand;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic                flush;
        logic                load;
        logic                drop;
        logic                shift;
        logic [POLICY_W-1:0] policy;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_HOLD
    } t_state;

endpackage

/* hdl/request_queue_scheduler.sv */
`timescale 1ns / 1ps
// ============================================================================
// request_queue_scheduler - bounded request queue with selectable service order
// Ring of DEPTH slot cells; FIFO, smallest-size-first or newest-first dequeue.
// ============================================================================
// Usage: each input transfer is an enqueue (func 0) or a dequeue (func 1) and
// yields exactly one result transfer with a status, the served connection id
// and the occupancy after the item. An enqueue, a rejected enqueue (queue
// full) and an empty dequeue go through HOLD before the next item is taken; a
// dequeue goes through SCAN, SHIFT and HOLD. The best-candidate search ripples
// through the chain of DEPTH slot cells one cell per cycle, then SHIFT closes
// any gap (cells from the removed slot to the last in use take their right
// neighbor) and HOLD hands the result to the output register, which lets a new
// item be accepted while the previous result still waits on o_out stall. Ties
// under SFF/RFF go to the lowest physical slot. Policy code three acts as
// FIFO. Writing slots_in_use empties the queue; values of 0 act as 1 and
// values above DEPTH act as DEPTH. Unknown register indexes are ignored.
// ============================================================================
module request_queue_scheduler #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rqs_pkg::t_in_item                   i_in_item,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rqs_pkg::t_out_item                  o_out_item,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rqs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rqs_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import rqs_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH+1);
    localparam int CW = (NW > OCC_W) ? NW : OCC_W;

    // configuration
    logic [POLICY_W-1:0]   r_policy;
    logic [CFG_DATA_W-1:0] r_slots;

    // queue control
    t_state                r_state,   n_state;
    logic [IW-1:0]         r_head,    n_head;
    logic [IW-1:0]         r_tail,    n_tail;
    logic [OCC_W-1:0]      r_count,   n_count;
    logic [IW-1:0]         r_scan,    n_scan;
    t_out_item             r_res,     n_res;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  w_in_xfer;
    logic                  w_cfg_slots;
    logic                  w_out_free;
    logic [NW-1:0]         w_n;
    logic [NW-1:0]         w_head_p1;
    logic [NW-1:0]         w_tail_p1;
    logic [IW-1:0]         w_head_inc;
    logic [IW-1:0]         w_tail_inc;
    logic [IW-1:0]         w_last;
    logic [IW-1:0]         w_target;
    logic [NW:0]           w_span_raw;
    logic [NW-1:0]         w_span;
    logic                  w_full;
    t_cell_cmd             w_cmd;
    t_slot                 w_new;

    // cell chain wiring
    t_slot                 w_slot     [DEPTH];
    logic [DEPTH-1:0]      w_valid;
    t_cand                 w_cand     [DEPTH];
    logic [IW-1:0]         w_cand_idx [DEPTH];
    t_slot                 w_nb_slot  [DEPTH];
    logic [DEPTH-1:0]      w_nb_valid;
    t_cand                 w_cand_in  [DEPTH];
    logic [IW-1:0]         w_cidx_in  [DEPTH];

    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_cfg_slots = i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_SLOTS);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // effective ring length, clamped to 1..DEPTH
    always_comb begin
        if (r_slots == '0) begin
            w_n = NW'(1);
        end else if (32'(r_slots) > 32'(DEPTH)) begin
            w_n = NW'(DEPTH);
        end else begin
            w_n = NW'(r_slots);
        end
    end

    // pointer arithmetic modulo the ring length
    always_comb begin
        w_head_p1  = NW'(r_head) + NW'(1);
        w_tail_p1  = NW'(r_tail) + NW'(1);
        w_head_inc = (w_head_p1 == w_n) ? '0 : IW'(w_head_p1);
        w_tail_inc = (w_tail_p1 == w_n) ? '0 : IW'(w_tail_p1);
        w_last     = (r_tail == '0) ? IW'(w_n - NW'(1)) : (r_tail - IW'(1));
        w_target   = w_cand_idx[DEPTH-1];
        // number of cells that take their neighbor: (last - target) mod n
        w_span_raw = {1'b0, NW'(w_last)} - {1'b0, NW'(w_target)};
        if (w_span_raw[NW]) begin
            w_span_raw = w_span_raw + {1'b0, w_n};
        end
        w_span = NW'(w_span_raw);
        w_full = CW'(r_count) >= CW'(w_n);
    end

    assign w_new = '{conn_id:   i_in_item.conn_id,
                     file_size: i_in_item.file_size,
                     mod_time:  i_in_item.mod_time};

    // sequencer: next state, queue pointers, cell commands, pending result
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_scan       = r_scan;
        n_res        = r_res;
        w_cmd        = '0;
        w_cmd.policy = r_policy;
        unique case (r_state)
            S_IDLE: begin
                n_scan = '0;
                if (w_in_xfer) begin
                    if (i_in_item.func == FN_ENQ) begin
                        if (w_full) begin
                            n_res = '{status: STAT_FULL, served_conn: '0,
                                      occupancy: r_count};
                        end else begin
                            w_cmd.load = 1'b1;
                            n_tail     = w_tail_inc;
                            n_count    = r_count + OCC_W'(1);
                            n_res      = '{status: STAT_DONE, served_conn: '0,
                                           occupancy: r_count + OCC_W'(1)};
                        end
                        n_state = S_HOLD;
                    end else if (r_count == '0) begin
                        n_res   = '{status: STAT_EMPTY, served_conn: '0,
                                    occupancy: '0};
                        n_state = S_HOLD;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // wait for the candidate to reach the last cell
                n_scan = r_scan + IW'(1);
                if (r_scan == IW'(DEPTH-1)) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (w_target == r_head) begin
                    w_cmd.drop = 1'b1;
                    n_head     = w_head_inc;
                end else begin
                    w_cmd.shift = 1'b1;
                    n_tail      = w_last;
                end
                n_count = r_count - OCC_W'(1);
                n_res   = '{status: STAT_DONE, served_conn: w_cand[DEPTH-1].conn_id,
                            occupancy: r_count - OCC_W'(1)};
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // ring resize empties the queue
        if (w_cfg_slots) begin
            w_cmd.flush = 1'b1;
            n_head      = '0;
            n_tail      = '0;
            n_count     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_scan   <= '0;
            r_policy <= POL_FIFO;
            r_slots  <= SLOTS_RESET;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_scan  <= n_scan;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_POLICY) begin
                    r_policy <= i_cfg_data[POLICY_W-1:0];
                end else if (i_cfg_index == CFG_SLOTS) begin
                    r_slots <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // output register: loaded from the pending result when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_HOLD) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_HOLD) && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    // slot cell chain; the last cell in use wraps to cell 0 for gap closing
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        if (gi == DEPTH-1) begin : g_wrap
            assign w_nb_slot[gi]  = w_slot[0];
            assign w_nb_valid[gi] = w_valid[0];
        end else begin : g_mid
            assign w_nb_slot[gi]  = (NW'(gi+1) == w_n) ? w_slot[0]  : w_slot[gi+1];
            assign w_nb_valid[gi] = (NW'(gi+1) == w_n) ? w_valid[0] : w_valid[gi+1];
        end
        if (gi == 0) begin : g_first
            assign w_cand_in[gi] = '0;
            assign w_cidx_in[gi] = '0;
        end else begin : g_next
            assign w_cand_in[gi] = w_cand[gi-1];
            assign w_cidx_in[gi] = w_cand_idx[gi-1];
        end

        rqs_cell #(
            .DEPTH (DEPTH),
            .IDX   (gi)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_head     (r_head),
            .i_tail     (r_tail),
            .i_target   (w_target),
            .i_last     (w_last),
            .i_n        (w_n),
            .i_span     (w_span),
            .i_new      (w_new),
            .i_nb_slot  (w_nb_slot[gi]),
            .i_nb_valid (w_nb_valid[gi]),
            .i_cand     (w_cand_in[gi]),
            .i_cand_idx (w_cidx_in[gi]),
            .o_slot     (w_slot[gi]),
            .o_valid    (w_valid[gi]),
            .o_cand     (w_cand[gi]),
            .o_cand_idx (w_cand_idx[gi])
        );
    end

    // queue never holds more than the ring length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_count) <= CW'(w_n))
        else $error("queue count above ring length");

    // occupied cells match the request count
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_count))
        else $error("valid slots disagree with queue count");

    // a search only runs on a non-empty queue
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_count != '0))
        else $error("search started on empty queue");

    // the search always finds a slot to serve
    a_cand_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> w_cand[DEPTH-1].found)
        else $error("no candidate at end of search");

endmodule

/* hdl/rqs_cell.sv */
`timescale 1ns / 1ps
// ============================================================================
// rqs_cell - one request slot of the queue chain
// Holds one slot, loads on enqueue, takes its right neighbor on gap close,
// and passes the best candidate on to the next cell each cycle.
// ============================================================================
module rqs_cell #(
    parameter int DEPTH = 16,
    parameter int IDX   = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rqs_pkg::t_cell_cmd             i_cmd,
    input  logic [$clog2(DEPTH)-1:0]       i_head,
    input  logic [$clog2(DEPTH)-1:0]       i_tail,
    input  logic [$clog2(DEPTH)-1:0]       i_target,
    input  logic [$clog2(DEPTH)-1:0]       i_last,
    input  logic [$clog2(DEPTH+1)-1:0]     i_n,
    input  logic [$clog2(DEPTH+1)-1:0]     i_span,
    input  rqs_pkg::t_slot                 i_new,
    input  rqs_pkg::t_slot                 i_nb_slot,
    input  logic                           i_nb_valid,
    input  rqs_pkg::t_cand                 i_cand,
    input  logic [$clog2(DEPTH)-1:0]       i_cand_idx,
    output rqs_pkg::t_slot                 o_slot,
    output logic                           o_valid,
    output rqs_pkg::t_cand                 o_cand,
    output logic [$clog2(DEPTH)-1:0]       o_cand_idx
);
    import rqs_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH+1);
    localparam int DW = NW + 1;
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);
    localparam logic [DW-1:0] MY_POS = DW'(IDX);

    t_slot           r_slot;
    logic            r_valid;
    t_cand           r_cand;
    logic [IW-1:0]   r_cand_idx;

    t_slot           n_slot;
    logic            n_valid;
    t_cand           n_cand;
    logic [IW-1:0]   n_cand_idx;

    logic            w_in_ring;
    logic [DW-1:0]   w_dist;
    logic            w_shift_me;
    logic            w_load_me;
    logic            w_elig;
    logic [SIZE_W-1:0] w_key;

    // ring distance from the removed slot, wraps modulo the ring length
    always_comb begin
        w_in_ring = MY_POS < {1'b0, i_n};
        w_dist    = MY_POS - DW'(i_target);
        if (w_dist[DW-1]) begin
            w_dist = w_dist + DW'(i_n);
        end
        w_shift_me = i_cmd.shift && w_in_ring && (w_dist < DW'(i_span));
        w_load_me  = i_cmd.load && (MY_IDX == i_tail);
    end

    // slot contents and valid
    always_comb begin
        n_slot  = r_slot;
        n_valid = r_valid;
        priority if (i_cmd.flush) begin
            n_valid = 1'b0;
        end else if (w_load_me) begin
            n_slot  = i_new;
            n_valid = 1'b1;
        end else if (w_shift_me) begin
            n_slot  = i_nb_slot;
            n_valid = i_nb_valid;
        end else if (i_cmd.shift && (MY_IDX == i_last)) begin
            n_valid = 1'b0;
        end else if (i_cmd.drop && (MY_IDX == i_target)) begin
            n_valid = 1'b0;
        end
    end

    // candidate select: smaller key wins, strict compare keeps lowest index
    always_comb begin
        w_key  = '0;
        w_elig = 1'b0;
        unique case (i_cmd.policy)
            POL_SFF: begin
                w_key  = r_slot.file_size;
                w_elig = r_valid;
            end
            POL_RFF: begin
                w_key  = ~r_slot.mod_time;
                w_elig = r_valid;
            end
            default: begin
                w_elig = r_valid && (MY_IDX == i_head);
            end
        endcase
        n_cand     = i_cand;
        n_cand_idx = i_cand_idx;
        if (w_elig && (!i_cand.found || (w_key < i_cand.key))) begin
            n_cand.key     = w_key;
            n_cand.conn_id = r_slot.conn_id;
            n_cand.found   = 1'b1;
            n_cand_idx     = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_cand     <= '0;
            r_cand_idx <= '0;
        end else begin
            r_valid    <= n_valid;
            r_cand     <= n_cand;
            r_cand_idx <= n_cand_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot     = r_slot;
    assign o_valid    = r_valid;
    assign o_cand     = r_cand;
    assign o_cand_idx = r_cand_idx;

endmodule

/* test/rqs_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// rqs_checker - scoreboard for the request queue scheduler
// Watches the request, result and register channels, keeps its own copy of
// the slot ring and compares each result transfer with the predicted reply.
// ============================================================================
module rqs_checker #(
    parameter int DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  rqs_pkg::t_in_item                  i_in_item,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  rqs_pkg::t_out_item                 i_out_item,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [rqs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rqs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import rqs_pkg::*;

    logic [CONN_W-1:0]     ring_conn [DEPTH];
    logic [SIZE_W-1:0]     ring_size [DEPTH];
    logic [MTIME_W-1:0]    ring_time [DEPTH];
    logic                  ring_live [DEPTH];
    int unsigned           rd_pos;
    int unsigned           wr_pos;
    int unsigned           n_queued;
    logic [POLICY_W-1:0]   svc_policy;
    logic [CFG_DATA_W-1:0] ring_slots;

    t_out_item replies_due [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void empty_ring();
        for (int i = 0; i < DEPTH; i++) ring_live[i] = 1'b0;
        rd_pos   = 0;
        wr_pos   = 0;
        n_queued = 0;
    endfunction

    function automatic int unsigned ring_len();
        if (ring_slots == 0) return 1;
        if (ring_slots > DEPTH) return DEPTH;
        return ring_slots;
    endfunction

    // drop slot pos (not the head): later entries slide down toward it
    function automatic void close_gap(int unsigned pos, int unsigned n);
        int unsigned last;
        int unsigned i;
        int unsigned nx;
        int unsigned guard;
        last  = (wr_pos + n - 1) % n;
        i     = pos;
        guard = 0;
        while (i != last && guard < n) begin
            nx           = (i + 1) % n;
            ring_conn[i] = ring_conn[nx];
            ring_size[i] = ring_size[nx];
            ring_time[i] = ring_time[nx];
            ring_live[i] = ring_live[nx];
            i            = nx;
            guard++;
        end
        ring_live[last] = 1'b0;
        if (last == rd_pos) rd_pos = (rd_pos + 1) % n;
        wr_pos = last;
    endfunction

    function automatic t_out_item schedule_request(t_in_item req);
        t_out_item         reply;
        int unsigned       n;
        int unsigned       target;
        logic              found;
        logic [SIZE_W-1:0] best;
        n      = ring_len();
        reply  = '0;
        reply.status = STAT_DONE;
        if (rd_pos >= n) rd_pos = rd_pos % n;
        if (wr_pos >= n) wr_pos = wr_pos % n;
        if (req.func == FN_ENQ) begin
            if (n_queued >= n) begin
                reply.status = STAT_FULL;
            end else begin
                ring_conn[wr_pos] = req.conn_id;
                ring_size[wr_pos] = req.file_size;
                ring_time[wr_pos] = req.mod_time;
                ring_live[wr_pos] = 1'b1;
                wr_pos            = (wr_pos + 1) % n;
                n_queued++;
            end
        end else if (n_queued == 0) begin
            reply.status = STAT_EMPTY;
        end else begin
            target = rd_pos;
            found  = 1'b0;
            best   = '0;
            // strict compare keeps the lowest physical slot on ties
            if (svc_policy == POL_SFF) begin
                for (int unsigned i = 0; i < n; i++) begin
                    if (ring_live[i] && (!found || ring_size[i] < best)) begin
                        best   = ring_size[i];
                        target = i;
                        found  = 1'b1;
                    end
                end
            end else if (svc_policy == POL_RFF) begin
                for (int unsigned i = 0; i < n; i++) begin
                    if (ring_live[i] && (!found || ring_time[i] > best)) begin
                        best   = ring_time[i];
                        target = i;
                        found  = 1'b1;
                    end
                end
            end
            reply.served_conn = ring_conn[target];
            ring_live[target] = 1'b0;
            if (target == rd_pos) rd_pos = (rd_pos + 1) % n;
            else close_gap(target, n);
            n_queued--;
        end
        reply.occupancy = n_queued[OCC_W-1:0];
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            svc_policy = POL_FIFO;
            ring_slots = SLOTS_RESET;
            empty_ring();
            replies_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    $error("result transfer with nothing outstanding: %p", i_out_item);
                    o_fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (i_out_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, i_out_item.status);
                        o_fail_count++;
                    end
                    if (i_out_item.served_conn !== want.served_conn) begin
                        $error("served_conn: expected %0h, got %0h",
                               want.served_conn, i_out_item.served_conn);
                        o_fail_count++;
                    end
                    if (i_out_item.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, i_out_item.occupancy);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_POLICY) begin
                    svc_policy = i_cfg_data[POLICY_W-1:0];
                end else if (i_cfg_index == CFG_SLOTS) begin
                    ring_slots = i_cfg_data;
                    empty_ring();
                end
            end
            if (i_in_valid && !i_in_stall) replies_due.push_back(schedule_request(i_in_item));
        end
        o_pending = replies_due.size();
    end

endmodule

/* test/tb_request_queue_scheduler.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_request_queue_scheduler - testbench for the request queue scheduler
// Directed enqueue/dequeue cases under every policy and ring size extreme,
// then random traffic across idle/stall phases; rqs_checker scores results.
// ============================================================================
module tb_request_queue_scheduler;
    import rqs_pkg::*;

    localparam int  DEPTH    = 16;
    localparam real CLK_HALF = 6.0;
    // far beyond the slowest legal run (every transfer a full-length dequeue
    // under the heaviest idle and stall mix)
    localparam int  LIMIT_NS = 5_000_000;

    // policy code three is not named in the package; the block treats it as FIFO
    localparam logic [POLICY_W-1:0]  POL_CODE3   = 2'd3;
    // register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;

    // percent chance per cycle of a sender gap / a receiver stall
    int idle_pct;
    int stall_pct;

    request_queue_scheduler #(.DEPTH(DEPTH)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rqs_checker #(.DEPTH(DEPTH)) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // receiver side: stalls at random, one decision per cycle
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic t_in_item make_request(logic func, logic [CONN_W-1:0] conn,
                                              logic [SIZE_W-1:0] size,
                                              logic [MTIME_W-1:0] mtime);
        t_in_item req;
        req.func      = func;
        req.conn_id   = conn;
        req.file_size = size;
        req.mod_time  = mtime;
        return req;
    endfunction

    // sort keys: a narrow set forces ties, extremes hit the compare edges
    function automatic logic [31:0] pick_key();
        case ($urandom_range(2))
            0:       return $urandom_range(3);
            1:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // one request transfer; random gaps ahead of it, then hold until taken
    task automatic send_request(input t_in_item req);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // hold off the sender until every outstanding reply is back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // register writes only go out with the queue quiet
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // policy in the low bits, junk above it that the block must drop
    task automatic write_policy(input logic [POLICY_W-1:0] pol);
        write_reg(CFG_POLICY, {3'($urandom_range(7)), pol});
    endtask

    initial begin
        logic [POLICY_W-1:0]   seg_policy [8];
        logic [CFG_DATA_W-1:0] seg_slots [8];
        int                    seg_idle [4];
        int                    seg_stall [4];
        int                    enq_pct;
        logic                  func;

        seg_policy = '{POL_FIFO, POL_SFF, POL_RFF, POL_CODE3,
                       POL_SFF, POL_RFF, POL_CODE3, POL_FIFO};
        seg_slots  = '{5'd1, 5'd16, 5'd2, 5'd0, 5'd31, 5'd3, 5'd7, 5'd16};
        // no idling / sender gaps / receiver stalls / both
        seg_idle   = '{0, 47, 0, 31};
        seg_stall  = '{0, 0, 47, 31};

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        idle_pct    = 0;
        stall_pct   = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed: reset config (FIFO, full ring) ----
        send_request(make_request(FN_DEQ, 16'h1234, 32'h0, 32'h0));   // empty dequeue
        send_request(make_request(FN_ENQ, 16'h0000, 32'h0, 32'h0));
        send_request(make_request(FN_ENQ, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_request(FN_DEQ, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_request(FN_DEQ, 16'h0, 32'h0, 32'h0));

        // ring size zero acts as one slot: second enqueue is rejected full
        write_reg(CFG_SLOTS, 5'd0);
        send_request(make_request(FN_ENQ, 16'h0001, 32'h10, 32'h20));
        send_request(make_request(FN_ENQ, 16'h0002, 32'h11, 32'h21));
        send_request(make_request(FN_DEQ, 16'h0, 32'h0, 32'h0));

        // oversize ring acts as DEPTH; SFF tie goes to the lower slot
        write_reg(CFG_SLOTS, 5'd31);
        write_policy(POL_SFF);
        send_request(make_request(FN_ENQ, 16'h0010, 32'd5, 32'd1));
        send_request(make_request(FN_ENQ, 16'h0011, 32'd3, 32'd7));
        send_request(make_request(FN_ENQ, 16'h0012, 32'd3, 32'd7));
        send_request(make_request(FN_ENQ, 16'h0013, 32'd9, 32'd2));
        send_request(make_request(FN_DEQ, 16'h0, 32'h0, 32'h0));

        // policy change keeps the queue; RFF pulls from the middle
        write_policy(POL_RFF);
        send_request(make_request(FN_DEQ, 16'h0, 32'h0, 32'h0));
        send_request(make_request(FN_DEQ, 16'h0, 32'h0, 32'h0));

        // code three behaves as FIFO, then drain to empty
        write_policy(POL_CODE3);
        send_request(make_request(FN_ENQ, 16'h0014, 32'd1, 32'd1));
        send_request(make_request(FN_DEQ, 16'h0, 32'h0, 32'h0));
        send_request(make_request(FN_DEQ, 16'h0, 32'h0, 32'h0));
        send_request(make_request(FN_DEQ, 16'h0, 32'h0, 32'h0));

        // writes to undecoded indexes must change nothing
        write_reg(CFG_SPARE_A, 5'd31);
        write_reg(CFG_SPARE_B, 5'd0);

        // tiny ring with wrap: SFF removal closes a gap across the wrap point
        // (head at slot 1, smallest in slot 2, tail entry in slot 0)
        write_policy(POL_SFF);
        write_reg(CFG_SLOTS, 5'd3);
        send_request(make_request(FN_ENQ, 16'h0020, 32'd8, 32'd0));
        send_request(make_request(FN_DEQ, 16'h0, 32'h0, 32'h0));
        send_request(make_request(FN_ENQ, 16'h0021, 32'd9, 32'd0));
        send_request(make_request(FN_ENQ, 16'h0022, 32'd1, 32'd0));
        send_request(make_request(FN_ENQ, 16'h0023, 32'd5, 32'd0));
        send_request(make_request(FN_DEQ, 16'h0, 32'h0, 32'h0));
        send_request(make_request(FN_DEQ, 16'h0, 32'h0, 32'h0));

        // ---- random: eight segments of mixed traffic ----
        for (int seg = 0; seg < 8; seg++) begin
            idle_pct  = 0;
            stall_pct = 0;
            write_policy(seg_policy[seg]);
            write_reg(CFG_SLOTS, seg_slots[seg]);
            idle_pct  = seg_idle[seg % 4];
            stall_pct = seg_stall[seg % 4];
            enq_pct   = 50;
            for (int k = 0; k < 144; k++) begin
                // alternate fill and drain bursts so both full and empty come up
                if (k % 24 == 0) enq_pct = $urandom_range(1) ? 75 : 30;
                if ($urandom_range(49) == 0) wait_drained();
                func = ($urandom_range(99) < enq_pct) ? FN_ENQ : FN_DEQ;
                send_request(make_request(func, 16'($urandom), pick_key(), pick_key()));
            end
        end

        wait_drained();
        repeat (DEPTH + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
